// ===== design/prbts_pkg.sv =====
// Package for the priority task scheduler with ready and blocked lists.
// Holds the item structs, command and status codes, and shared constants.
// No dependencies; every other design file imports it.
package prbts_pkg;

	// Field widths fixed by the item layout.
	localparam int PRIORITY_BITS = 8;
	localparam int HANDLE_BITS   = 16;
	localparam int MASK_BITS     = 32;
	localparam int FLAG_SEL_BITS = 3;
	localparam int SLOT_OUT_BITS = 5;

	// Default sizes for the top-level parameters.
	localparam int DEF_SLOTS           = 32;
	localparam int DEF_PENDING_DEPTH   = 32;
	localparam int DEF_FLAG_WORD_COUNT = 8;

	// Command codes.
	localparam logic [1:0] CMD_QUEUE    = 2'd0;
	localparam logic [1:0] CMD_FLAG     = 2'd1;
	localparam logic [1:0] CMD_DISPATCH = 2'd2;

	// Status codes.
	localparam logic [2:0] ST_QUEUED     = 3'd0;
	localparam logic [2:0] ST_DROPPED    = 3'd1;
	localparam logic [2:0] ST_FLAG       = 3'd2;
	localparam logic [2:0] ST_DISPATCHED = 3'd3;
	localparam logic [2:0] ST_IDLE       = 3'd4;

	typedef struct packed {
		logic [1:0]               command;
		logic [PRIORITY_BITS-1:0] task_priority;
		logic [MASK_BITS-1:0]     task_mask;
		logic [FLAG_SEL_BITS-1:0] task_flag_sel;
		logic [HANDLE_BITS-1:0]   task_ident;
		logic [FLAG_SEL_BITS-1:0] flag_sel;
		logic [MASK_BITS-1:0]     flag_value;
	} in_item_t;

	typedef struct packed {
		logic [2:0]               status;
		logic [SLOT_OUT_BITS-1:0] slot;
		logic [HANDLE_BITS-1:0]   dispatched_ident;
		logic [PRIORITY_BITS-1:0] dispatched_priority;
	} out_item_t;

	// One stored task record.
	typedef struct packed {
		logic [PRIORITY_BITS-1:0] prio;
		logic [MASK_BITS-1:0]     mask;
		logic [FLAG_SEL_BITS-1:0] flag_idx;
		logic [HANDLE_BITS-1:0]   handle;
	} slot_rec_t;

	// Results of the shared evaluation unit.
	typedef struct packed {
		logic ready;
		logic above;
		logic below;
	} eval_t;

endpackage

// ===== design/prbts_store.sv =====
// Task record memory and link memory of the scheduler.
// One write port each, one shared read address, registered read data. Uses prbts_pkg.
module prbts_store
	import prbts_pkg::*;
#(
	parameter int SLOTS = DEF_SLOTS
) (
	input  logic                       clk,
	input  logic                       rec_we,
	input  logic [$clog2(SLOTS)-1:0]   rec_waddr,
	input  slot_rec_t                  rec_wdata,
	input  logic                       link_we,
	input  logic [$clog2(SLOTS)-1:0]   link_waddr,
	input  logic [$clog2(SLOTS+1)-1:0] link_wdata,
	input  logic [$clog2(SLOTS)-1:0]   rd_addr,
	output slot_rec_t                  rec_rd,
	output logic [$clog2(SLOTS+1)-1:0] link_rd
);

	slot_rec_t                  rec_mem [SLOTS];
	logic [$clog2(SLOTS+1)-1:0] link_mem [SLOTS];

	// Record memory: written when a task is queued.
	always_ff @(posedge clk) begin
		if (rec_we) begin
			rec_mem[rec_waddr] <= rec_wdata;
		end
		rec_rd <= rec_mem[rd_addr];
	end

	// Link memory: written while lists are relinked.
	always_ff @(posedge clk) begin
		if (link_we) begin
			link_mem[link_waddr] <= link_wdata;
		end
		link_rd <= link_mem[rd_addr];
	end

endmodule

// ===== design/prbts_eval.sv =====
// Shared evaluation unit: flag words, readiness test and priority compares.
// Applied to the record read out of the store each cycle. Uses prbts_pkg.
module prbts_eval
	import prbts_pkg::*;
#(
	parameter int FLAG_WORD_COUNT = DEF_FLAG_WORD_COUNT
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     flag_we,
	input  logic [FLAG_SEL_BITS-1:0] flag_sel,
	input  logic [MASK_BITS-1:0]     flag_value,
	input  slot_rec_t                rec,
	input  logic [PRIORITY_BITS-1:0] ins_prio,
	input  logic [PRIORITY_BITS-1:0] ref_prio,
	input  logic                     ref_nil,
	output eval_t                    ev
);

	// Only the first eight words can ever be addressed.
	localparam int FLAG_DEPTH = (FLAG_WORD_COUNT < 8) ? FLAG_WORD_COUNT : 8;
	localparam int FIDX_W     = (FLAG_DEPTH > 1) ? $clog2(FLAG_DEPTH) : 1;

	logic [MASK_BITS-1:0] flag_q [FLAG_DEPTH];
	logic [MASK_BITS-1:0] word;

	// Flag word registers; writes beyond the word count are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < FLAG_DEPTH; i++) begin
				flag_q[i] <= '0;
			end
		end else if (flag_we && (32'(flag_sel) < FLAG_DEPTH)) begin
			flag_q[flag_sel[FIDX_W-1:0]] <= flag_value;
		end
	end

	// Readiness test and the two priority compares.
	always_comb begin
		word = '0;
		if (32'(rec.flag_idx) < FLAG_DEPTH) begin
			word = flag_q[rec.flag_idx[FIDX_W-1:0]];
		end
		ev.ready = ((word & rec.mask) == rec.mask);
		ev.above = ref_nil || (rec.prio > ref_prio);
		ev.below = (ins_prio > rec.prio);
	end

endmodule

// ===== design/priority_ready_blocked_task_scheduler.sv =====
// Priority task scheduler with a ready list and a blocked list.
// Command channel: an item is taken when start is high and busy is low.
// Result channel: done is high for one cycle with the result on result; the
// receiver must take it then, since it cannot stall the block.
//
// Queue and flag-write items are handled directly: the result appears in the
// cycle after the item is taken, and busy stays low. Command code three is
// ignored and produces no result.
// A dispatch item is run by a small sequencer that walks the linked lists
// through one record/link memory read port and one evaluation unit, one list
// node per cycle. Busy stays high while tasks are drained from the pending
// ring or moved to the blocked list and list nodes are read; the result
// comes in the same cycle as busy falls.
//
// Reset clears the flag words, frees every slot, empties both lists and the
// pending ring. The record memories need no clearing.
module priority_ready_blocked_task_scheduler
	import prbts_pkg::*;
#(
	parameter int SLOTS           = DEF_SLOTS,
	parameter int PENDING_DEPTH   = DEF_PENDING_DEPTH,
	parameter int FLAG_WORD_COUNT = DEF_FLAG_WORD_COUNT
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	output logic      busy,
	input  in_item_t  request,
	output logic      done,
	output out_item_t result
);

	localparam int SW = $clog2(SLOTS);
	localparam int LW = $clog2(SLOTS+1);
	localparam int PW = $clog2(PENDING_DEPTH);
	localparam logic [LW-1:0] NIL = LW'(SLOTS);

	typedef enum logic [10:0] {
		S_IDLE      = 11'b00000000001,
		S_DR_CHECK  = 11'b00000000010,
		S_DR_EVAL   = 11'b00000000100,
		S_INS_START = 11'b00000001000,
		S_INS_WALK  = 11'b00000010000,
		S_FIX       = 11'b00000100000,
		S_PR_START  = 11'b00001000000,
		S_PR_RPRIO  = 11'b00010000000,
		S_PR_WALK   = 11'b00100000000,
		S_DM_START  = 11'b01000000000,
		S_DM_EVAL   = 11'b10000000000
	} state_t;

	state_t state_q, state_d, ret_q, ret_d;
	logic [SLOTS-1:0] slot_free_q, slot_free_d;
	logic [LW-1:0] ready_head_q, ready_head_d, blocked_head_q, blocked_head_d;
	logic [PW-1:0] rp_q, rp_d, wp_q, wp_d;
	logic [SW-1:0] ring_q [PENDING_DEPTH];
	logic [SW-1:0] ins_s_q, ins_s_d, cur_q, cur_d, prev_q, prev_d, fix_addr_q, fix_addr_d;
	logic prev_nil_q, prev_nil_d, ins_blk_q, ins_blk_d, rnil_q, rnil_d;
	logic [LW-1:0] fix_data_q, fix_data_d;
	logic [PRIORITY_BITS-1:0] ins_prio_q, ins_prio_d, rprio_q, rprio_d;
	out_item_t result_q, result_d;
	logic done_q, done_d;

	logic rec_we, link_we, ring_we, flag_we;
	logic [SW-1:0] rd_addr, link_waddr, free_idx;
	logic [LW-1:0] link_wdata, head;
	slot_rec_t rec_wdata, rec_rd;
	logic [LW-1:0] link_rd;
	logic any_free, nxt_nil;
	eval_t ev;

	prbts_store #(.SLOTS(SLOTS)) u_store (
		.clk        (clk),
		.rec_we     (rec_we),
		.rec_waddr  (free_idx),
		.rec_wdata  (rec_wdata),
		.link_we    (link_we),
		.link_waddr (link_waddr),
		.link_wdata (link_wdata),
		.rd_addr    (rd_addr),
		.rec_rd     (rec_rd),
		.link_rd    (link_rd)
	);

	prbts_eval #(.FLAG_WORD_COUNT(FLAG_WORD_COUNT)) u_eval (
		.clk        (clk),
		.arst_n     (arst_n),
		.flag_we    (flag_we),
		.flag_sel   (request.flag_sel),
		.flag_value (request.flag_value),
		.rec        (rec_rd),
		.ins_prio   (ins_prio_q),
		.ref_prio   (rprio_q),
		.ref_nil    (rnil_q),
		.ev         (ev)
	);

	// Lowest free slot.
	always_comb begin
		free_idx = '0;
		for (int i = SLOTS-1; i >= 0; i--) begin
			if (slot_free_q[i]) begin
				free_idx = SW'(i);
			end
		end
		any_free = |slot_free_q;
	end

	assign rec_wdata = '{prio: request.task_priority, mask: request.task_mask,
		flag_idx: request.task_flag_sel, handle: request.task_ident};
	assign nxt_nil = (link_rd == NIL);
	assign head    = ins_blk_q ? blocked_head_q : ready_head_q;
	assign busy    = (state_q != S_IDLE);
	assign done    = done_q;
	assign result  = result_q;

	// Sequencer: next state, list relinking and memory controls.
	always_comb begin
		state_d        = state_q;
		ret_d          = ret_q;
		slot_free_d    = slot_free_q;
		ready_head_d   = ready_head_q;
		blocked_head_d = blocked_head_q;
		rp_d           = rp_q;
		wp_d           = wp_q;
		ins_s_d        = ins_s_q;
		ins_prio_d     = ins_prio_q;
		ins_blk_d      = ins_blk_q;
		cur_d          = cur_q;
		prev_d         = prev_q;
		prev_nil_d     = prev_nil_q;
		fix_addr_d     = fix_addr_q;
		fix_data_d     = fix_data_q;
		rprio_d        = rprio_q;
		rnil_d         = rnil_q;
		result_d       = result_q;
		done_d         = 1'b0;
		rec_we         = 1'b0;
		ring_we        = 1'b0;
		flag_we        = 1'b0;
		link_we        = 1'b0;
		link_waddr     = '0;
		link_wdata     = '0;
		rd_addr        = '0;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					unique case (request.command)
						CMD_QUEUE: begin
							done_d   = 1'b1;
							result_d = '{ST_DROPPED, '0, '0, '0};
							if (any_free) begin
								rec_we                = 1'b1;
								ring_we               = 1'b1;
								slot_free_d[free_idx] = 1'b0;
								wp_d = (wp_q == PW'(PENDING_DEPTH-1)) ? '0 : wp_q + 1'b1;
								result_d = '{ST_QUEUED, SLOT_OUT_BITS'(free_idx), '0, '0};
							end
						end
						CMD_FLAG: begin
							flag_we  = 1'b1;
							done_d   = 1'b1;
							result_d = '{ST_FLAG, '0, '0, '0};
						end
						CMD_DISPATCH: begin
							state_d = S_DR_CHECK;
						end
						default: begin
						end
					endcase
				end
			end
			// Drain the pending ring one task at a time.
			S_DR_CHECK: begin
				if (rp_q == wp_q) begin
					state_d = S_PR_START;
				end else begin
					rd_addr = ring_q[rp_q];
					ins_s_d = ring_q[rp_q];
					rp_d    = (rp_q == PW'(PENDING_DEPTH-1)) ? '0 : rp_q + 1'b1;
					state_d = S_DR_EVAL;
				end
			end
			S_DR_EVAL: begin
				ins_prio_d = rec_rd.prio;
				ins_blk_d  = !ev.ready;
				ret_d      = S_DR_CHECK;
				state_d    = S_INS_START;
			end
			// Sorted insert: walk until a node of lower priority or the tail.
			S_INS_START: begin
				if (head == NIL) begin
					link_we    = 1'b1;
					link_waddr = ins_s_q;
					link_wdata = NIL;
					if (ins_blk_q) blocked_head_d = LW'(ins_s_q);
					else ready_head_d = LW'(ins_s_q);
					state_d = ret_q;
				end else begin
					rd_addr    = head[SW-1:0];
					cur_d      = head[SW-1:0];
					prev_nil_d = 1'b1;
					state_d    = S_INS_WALK;
				end
			end
			S_INS_WALK: begin
				if (ev.below) begin
					link_we    = 1'b1;
					link_waddr = ins_s_q;
					link_wdata = LW'(cur_q);
					if (prev_nil_q) begin
						if (ins_blk_q) blocked_head_d = LW'(ins_s_q);
						else ready_head_d = LW'(ins_s_q);
						state_d = ret_q;
					end else begin
						fix_addr_d = prev_q;
						fix_data_d = LW'(ins_s_q);
						state_d    = S_FIX;
					end
				end else if (nxt_nil) begin
					link_we    = 1'b1;
					link_waddr = cur_q;
					link_wdata = LW'(ins_s_q);
					fix_addr_d = ins_s_q;
					fix_data_d = NIL;
					state_d    = S_FIX;
				end else begin
					prev_d     = cur_q;
					prev_nil_d = 1'b0;
					cur_d      = link_rd[SW-1:0];
					rd_addr    = link_rd[SW-1:0];
				end
			end
			// Second link write of a relink.
			S_FIX: begin
				link_we    = 1'b1;
				link_waddr = fix_addr_q;
				link_wdata = fix_data_q;
				state_d    = ret_q;
			end
			// Promote the first ready blocked task that outranks the ready head.
			S_PR_START: begin
				if (blocked_head_q == NIL) begin
					state_d = S_DM_START;
				end else if (ready_head_q == NIL) begin
					rnil_d     = 1'b1;
					rd_addr    = blocked_head_q[SW-1:0];
					cur_d      = blocked_head_q[SW-1:0];
					prev_nil_d = 1'b1;
					state_d    = S_PR_WALK;
				end else begin
					rnil_d  = 1'b0;
					rd_addr = ready_head_q[SW-1:0];
					state_d = S_PR_RPRIO;
				end
			end
			S_PR_RPRIO: begin
				rprio_d    = rec_rd.prio;
				rd_addr    = blocked_head_q[SW-1:0];
				cur_d      = blocked_head_q[SW-1:0];
				prev_nil_d = 1'b1;
				state_d    = S_PR_WALK;
			end
			S_PR_WALK: begin
				if (!ev.above) begin
					state_d = S_DM_START;
				end else if (ev.ready) begin
					ready_head_d = LW'(cur_q);
					link_we      = 1'b1;
					if (prev_nil_q) begin
						blocked_head_d = link_rd;
						link_waddr     = cur_q;
						link_wdata     = ready_head_q;
						state_d        = S_DM_START;
					end else begin
						link_waddr = prev_q;
						link_wdata = link_rd;
						fix_addr_d = cur_q;
						fix_data_d = ready_head_q;
						ret_d      = S_DM_START;
						state_d    = S_FIX;
					end
				end else if (nxt_nil) begin
					state_d = S_DM_START;
				end else begin
					prev_d     = cur_q;
					prev_nil_d = 1'b0;
					cur_d      = link_rd[SW-1:0];
					rd_addr    = link_rd[SW-1:0];
				end
			end
			// Move non-ready heads to the blocked list, then dispatch.
			S_DM_START: begin
				if (ready_head_q == NIL) begin
					done_d   = 1'b1;
					result_d = '{ST_IDLE, '0, '0, '0};
					state_d  = S_IDLE;
				end else begin
					rd_addr = ready_head_q[SW-1:0];
					cur_d   = ready_head_q[SW-1:0];
					state_d = S_DM_EVAL;
				end
			end
			S_DM_EVAL: begin
				ready_head_d = link_rd;
				if (ev.ready) begin
					slot_free_d[cur_q] = 1'b1;
					done_d   = 1'b1;
					result_d = '{ST_DISPATCHED, SLOT_OUT_BITS'(cur_q), rec_rd.handle,
						rec_rd.prio};
					state_d  = S_IDLE;
				end else begin
					ins_s_d    = cur_q;
					ins_prio_d = rec_rd.prio;
					ins_blk_d  = 1'b1;
					ret_d      = S_DM_START;
					state_d    = S_INS_START;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			ret_q          <= S_IDLE;
			slot_free_q    <= '1;
			ready_head_q   <= NIL;
			blocked_head_q <= NIL;
			rp_q           <= '0;
			wp_q           <= '0;
			done_q         <= 1'b0;
		end else begin
			state_q        <= state_d;
			ret_q          <= ret_d;
			slot_free_q    <= slot_free_d;
			ready_head_q   <= ready_head_d;
			blocked_head_q <= blocked_head_d;
			rp_q           <= rp_d;
			wp_q           <= wp_d;
			done_q         <= done_d;
		end
	end

	// Working registers and the pending ring.
	always_ff @(posedge clk) begin
		ins_s_q    <= ins_s_d;
		ins_prio_q <= ins_prio_d;
		ins_blk_q  <= ins_blk_d;
		cur_q      <= cur_d;
		prev_q     <= prev_d;
		prev_nil_q <= prev_nil_d;
		fix_addr_q <= fix_addr_d;
		fix_data_q <= fix_data_d;
		rprio_q    <= rprio_d;
		rnil_q     <= rnil_d;
		result_q   <= result_d;
		if (ring_we) begin
			ring_q[wp_q] <= free_idx;
		end
	end

endmodule

// ===== dv/sched_checker.sv =====
// Checker for the priority task scheduler: watches the command and result channels.
// Predicts each result with its own copy of the slot table and lists.
// Depends on prbts_pkg.
module sched_checker
	import prbts_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	input  logic      busy,
	input  in_item_t  request,
	input  logic      done,
	input  out_item_t result,
	output int        fail_count,
	output int        pending_results
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NSLOT = 32;
	localparam int NIL = 32;

	logic [31:0] flags [8];
	logic [31:0] free_map;
	logic [7:0]  s_prio [NSLOT];
	logic [31:0] s_mask [NSLOT];
	logic [2:0]  s_fsel [NSLOT];
	logic [15:0] s_hand [NSLOT];
	int          s_link [NSLOT];
	int          rdy_head, blk_head;
	int          ring [32];
	int          wr_pos, rd_pos;
	out_item_t   expected_results [$];
	int          mismatches;

	assign fail_count = mismatches;
	assign pending_results = expected_results.size();

	function automatic bit is_ready(int s);
		return (flags[s_fsel[s]] & s_mask[s]) == s_mask[s];
	endfunction

	// Insert after every entry of higher or equal priority.
	function automatic void insert_sorted(ref int head, input int s);
		int p, q;
		if (head == NIL || s_prio[s] > s_prio[head]) begin
			s_link[s] = head;
			head = s;
			return;
		end
		p = head;
		forever begin
			q = s_link[p];
			if (q == NIL || s_prio[q] < s_prio[s]) break;
			p = q;
		end
		s_link[s] = s_link[p];
		s_link[p] = s;
	endfunction

	function automatic bit outranks(int b, int r);
		return r == NIL || s_prio[b] > s_prio[r];
	endfunction

	// Move at most one ready blocked task that outranks the ready head.
	function automatic void promote_one();
		int b, r, p, q;
		b = blk_head;
		r = rdy_head;
		if (b == NIL || !outranks(b, r)) return;
		if (is_ready(b)) begin
			blk_head = s_link[b];
			s_link[b] = r;
			rdy_head = b;
			return;
		end
		p = b;
		forever begin
			q = s_link[p];
			if (q == NIL || !outranks(q, r)) return;
			if (is_ready(q)) begin
				s_link[p] = s_link[q];
				s_link[q] = r;
				rdy_head = q;
				return;
			end
			p = q;
		end
	endfunction

	function automatic out_item_t schedule_step(in_item_t it);
		out_item_t o;
		int s;
		o = '0;
		case (it.command)
			CMD_QUEUE: begin
				s = NIL;
				for (int i = NSLOT - 1; i >= 0; i--) if (free_map[i]) s = i;
				if (s == NIL) begin
					o.status = ST_DROPPED;
				end else begin
					free_map[s] = 1'b0;
					s_prio[s] = it.task_priority;
					s_mask[s] = it.task_mask;
					s_fsel[s] = it.task_flag_sel;
					s_hand[s] = it.task_ident;
					s_link[s] = NIL;
					ring[wr_pos] = s;
					wr_pos = (wr_pos + 1) % 32;
					o.status = ST_QUEUED;
					o.slot = s[4:0];
				end
			end
			CMD_FLAG: begin
				flags[it.flag_sel] = it.flag_value;
				o.status = ST_FLAG;
			end
			default: begin
				while (rd_pos != wr_pos) begin
					s = ring[rd_pos];
					if (is_ready(s)) insert_sorted(rdy_head, s);
					else insert_sorted(blk_head, s);
					rd_pos = (rd_pos + 1) % 32;
				end
				promote_one();
				for (int n = 0; n < NSLOT && rdy_head != NIL && !is_ready(rdy_head); n++) begin
					s = rdy_head;
					rdy_head = s_link[s];
					insert_sorted(blk_head, s);
				end
				if (rdy_head != NIL) begin
					s = rdy_head;
					o.status = ST_DISPATCHED;
					o.slot = s[4:0];
					o.dispatched_ident = s_hand[s];
					o.dispatched_priority = s_prio[s];
					rdy_head = s_link[s];
					free_map[s] = 1'b1;
				end else begin
					o.status = ST_IDLE;
				end
			end
		endcase
		return o;
	endfunction

	// Predict on accepted items, compare on strobed results.
	always @(posedge clk or negedge arst_n) begin
		out_item_t e;
		if (!arst_n) begin
			for (int i = 0; i < 8; i++) flags[i] = '0;
			free_map = '1;
			rdy_head = NIL;
			blk_head = NIL;
			wr_pos = 0;
			rd_pos = 0;
			expected_results.delete();
			mismatches = 0;
		end else begin
			if (done) begin
				if (expected_results.size() == 0) begin
					if (mismatches < 10) $display("unexpected result %h", result);
					mismatches++;
				end else begin
					e = expected_results.pop_front();
					if (result.status !== e.status || result.slot !== e.slot ||
							result.dispatched_ident !== e.dispatched_ident ||
							result.dispatched_priority !== e.dispatched_priority) begin
						if (mismatches < 10)
							$display("result mismatch: expected %h, got %h", e, result);
						mismatches++;
					end
				end
			end
			if (start && !busy && request.command != 2'd3)
				expected_results.push_back(schedule_step(request));
		end
	end
endmodule

// ===== dv/tb_top.sv =====
// Top of the scheduler testbench: clock, reset, command stimulus and verdict.
// Depends on prbts_pkg, sched_checker and the scheduler RTL.
module tb_top
	import prbts_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      start = 1'b0;
	logic      busy, done;
	in_item_t  request = '0;
	out_item_t result;
	int        fail_count, pending_results;
	int        sender_idle = 0;

	always #5 clk = ~clk;

	priority_ready_blocked_task_scheduler DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.request(request), .done(done), .result(result)
	);

	sched_checker checker_i (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .request(request),
		.done(done), .result(result), .fail_count(fail_count),
		.pending_results(pending_results)
	);

	// Hold one item on the channel until it is taken.
	task automatic send_item(in_item_t it);
		while ($urandom_range(99) < sender_idle) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		request <= it;
		do @(posedge clk); while (busy);
	endtask

	function automatic in_item_t make_item(logic [1:0] cmd, logic [7:0] pr,
			logic [31:0] mk, logic [2:0] fs, logic [15:0] id,
			logic [2:0] wsel, logic [31:0] wval);
		in_item_t it;
		it.command = cmd;
		it.task_priority = pr;
		it.task_mask = mk;
		it.task_flag_sel = fs;
		it.task_ident = id;
		it.flag_sel = wsel;
		it.flag_value = wval;
		return it;
	endfunction

	// Random item biased toward few sparse flag bits so tasks unblock often.
	function automatic in_item_t random_item();
		in_item_t it;
		int r;
		it = make_item(CMD_QUEUE, 8'($urandom), $urandom, 3'($urandom), 16'($urandom),
			3'($urandom), $urandom);
		r = $urandom_range(99);
		if (r < 45) it.command = CMD_QUEUE;
		else if (r < 65) it.command = CMD_FLAG;
		else if (r < 98) it.command = CMD_DISPATCH;
		else it.command = 2'd3;
		if ($urandom_range(3) != 0) it.task_mask = 32'h1 << $urandom_range(3);
		if ($urandom_range(2) != 0) it.task_priority = 8'($urandom_range(3));
		if ($urandom_range(1)) it.flag_value = $urandom_range(15);
		return it;
	endfunction

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// Directed: idle, extremes, flag writes, blocked tasks, command three.
		send_item(make_item(CMD_DISPATCH, 0, 0, 0, 0, 0, 0));
		send_item(make_item(CMD_QUEUE, 8'hff, 32'hffffffff, 3'd7, 16'hffff, 0, 0));
		send_item(make_item(CMD_QUEUE, 8'h00, 32'h0, 3'd0, 16'h0, 0, 0));
		send_item(make_item(CMD_QUEUE, 8'h00, 32'h1, 3'd0, 16'h1234, 0, 0));
		send_item(make_item(CMD_DISPATCH, 0, 0, 0, 0, 0, 0));
		send_item(make_item(CMD_DISPATCH, 0, 0, 0, 0, 0, 0));
		send_item(make_item(CMD_FLAG, 0, 0, 0, 0, 3'd7, 32'hffffffff));
		send_item(make_item(CMD_FLAG, 0, 0, 0, 0, 3'd0, 32'h1));
		send_item(make_item(2'd3, 8'h55, 0, 0, 16'h5555, 0, 0));
		send_item(make_item(CMD_DISPATCH, 0, 0, 0, 0, 0, 0));
		send_item(make_item(CMD_DISPATCH, 0, 0, 0, 0, 0, 0));
		send_item(make_item(CMD_DISPATCH, 0, 0, 0, 0, 0, 0));
		// Fill every slot and overrun the pending ring, then one drop.
		for (int i = 0; i < 33; i++)
			send_item(make_item(CMD_QUEUE, i[7:0], 32'h0, 3'd1, i[15:0], 0, 0));
		send_item(make_item(CMD_FLAG, 0, 0, 0, 0, 3'd0, 32'h0));
		for (int i = 0; i < 3; i++) send_item(make_item(CMD_DISPATCH, 0, 0, 0, 0, 0, 0));
		// Random phases with different sender idling.
		for (int ph = 0; ph < 3; ph++) begin
			sender_idle = (ph == 0) ? 24 : (ph == 1) ? 66 : 0;
			for (int i = 0; i < 490; i++) send_item(random_item());
			start <= 1'b0;
			while (pending_results != 0) @(posedge clk);
			for (int i = 0; i < 40; i++) send_item(make_item(CMD_DISPATCH, 0, 0, 0, 0, 0, 0));
			start <= 1'b0;
		end
		while (pending_results != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (fail_count == 0 && pending_results == 0) $display("simulation ok");
		else $display("simulation failed");
		$finish;
	end

	initial begin
		#100ms;
		$display("simulation failed");
		$finish;
	end
endmodule
